/* rtl/lbcd_pkg.sv */
package lbcd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DOWN  = 2'd1,
        PH_UP    = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ONE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TWO    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_THREE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_FOUR   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_WINDOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLICKS    = 3'd6;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;

    localparam logic [1:0] COUNT_MAX = 2'd3;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [15:0] CLICK_RESET    = 16'd400;
    localparam logic [1:0]  MAX_CLICKS_RESET = 2'd1;

    localparam int unsigned TIME_W = 32;

endpackage

/* rtl/ladder_button_click_detector.sv */
// Channel | Dir | Fields (low bit first)                           | Handshake
// s_      | in  | adc_sample[SAMPLE_BITS], time_ms[32], zero pad   | s_tvalid/s_tready
// m_      | out | event_kind[2], button_index[2], zero pad         | m_tvalid/m_tready
// cfg_    | in  | cfg_index[3], cfg_data[20]                       | cfg_valid/cfg_ready
//
// One word per cycle while m_tready holds: a word waits in the input register, then
// the classify/debounce/click logic updates state and loads the result register.
// The input word is registered first; the result register is loaded from that stage.
// Every input word yields exactly one result word (event_kind 0 when nothing fired).
// aresetn is synchronous, active low; config and state return to their defaults.
// A stalled result holds both stages; s_tready drops only when both are full.
module ladder_button_click_detector #(
    parameter int unsigned BUTTON_COUNT = 4,
    parameter int unsigned SAMPLE_BITS  = 10,
    localparam int unsigned S_DATA_W    = ((SAMPLE_BITS + 32 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // adc_sample, time_ms, zero pad
    input  logic [S_DATA_W-1:0]               s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // event_kind [1:0], button_index [3:2], zero pad
    output logic [7:0]                        m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lbcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lbcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lbcd_pkg::*;

    localparam int unsigned WIN_EXT_W = 2 * SAMPLE_BITS;
    localparam int unsigned LEVEL_W   = $clog2(BUTTON_COUNT + 1);
    localparam int unsigned SLOT_W    = $clog2(BUTTON_COUNT);

    // configuration
    logic [CFG_DATA_W-1:0] window_reg [BUTTON_COUNT];
    logic [15:0]           debounce_reg;
    logic [15:0]           click_window_reg;
    logic [1:0]            max_clicks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                window_reg[i] <= '0;
            end
            debounce_reg     <= DEBOUNCE_RESET;
            click_window_reg <= CLICK_RESET;
            max_clicks_reg   <= MAX_CLICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WINDOW_ONE, REG_WINDOW_TWO, REG_WINDOW_THREE, REG_WINDOW_FOUR: begin
                    window_reg[cfg_index[SLOT_W-1:0]] <= cfg_data;
                end
                REG_DEBOUNCE_TIME: debounce_reg     <= cfg_data[15:0];
                REG_CLICK_WINDOW:  click_window_reg <= cfg_data[15:0];
                REG_MAX_CLICKS:    max_clicks_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [TIME_W-1:0]      time_reg;
    logic                   out_valid_reg;
    logic [1:0]             kind_reg;
    logic [1:0]             button_reg;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            time_reg   <= s_tdata[SAMPLE_BITS +: TIME_W];
        end
    end

    // classify: first matching window wins
    logic [LEVEL_W-1:0] raw_level;

    always_comb begin
        logic [WIN_EXT_W-1:0]   win_ext;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        raw_level = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            win_ext = WIN_EXT_W'({{WIN_EXT_W{1'b0}}, window_reg[i]});
            lo      = win_ext[SAMPLE_BITS-1:0];
            hi      = win_ext[WIN_EXT_W-1:SAMPLE_BITS];
            if (sample_reg >= lo && sample_reg <= hi) begin
                raw_level = LEVEL_W'(i + 1);
            end
        end
    end

    // state
    phase_t              phase_reg,        phase_next;
    logic [TIME_W-1:0]   start_time_reg,   start_time_next;
    logic [LEVEL_W-1:0]  last_raw_reg,     last_raw_next;
    logic [TIME_W-1:0]   change_time_reg,  change_time_next;
    logic [LEVEL_W-1:0]  stable_reg,       stable_next;
    logic [SLOT_W-1:0]   slot_reg,         slot_next;
    // only the latched button's count can be nonzero, so one counter suffices
    logic [1:0]          count_reg,        count_next;
    logic [1:0]          kind_next;
    logic [1:0]          button_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            start_time_reg  <= '0;
            last_raw_reg    <= '0;
            change_time_reg <= '0;
            stable_reg      <= '0;
            slot_reg        <= '1;
            count_reg       <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            start_time_reg  <= start_time_next;
            last_raw_reg    <= last_raw_next;
            change_time_reg <= change_time_next;
            stable_reg      <= stable_next;
            slot_reg        <= slot_next;
            count_reg       <= count_next;
        end
    end

    always_comb begin
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] elapsed;
        logic              active;
        last_raw_next    = last_raw_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        held             = time_reg - change_time_reg;
        if (raw_level == last_raw_reg) begin
            if (held >= TIME_W'(debounce_reg)) begin
                stable_next = raw_level;
            end
        end else begin
            change_time_next = time_reg;
            last_raw_next    = raw_level;
        end

        active          = stable_next != '0;
        elapsed         = time_reg - start_time_reg;
        phase_next      = phase_reg;
        start_time_next = start_time_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        kind_next       = EV_NONE;
        button_next     = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (active) begin
                    phase_next      = PH_DOWN;
                    start_time_next = time_reg;
                    count_next      = '0;
                    slot_next       = SLOT_W'(stable_next - LEVEL_W'(1));
                end
            end
            PH_DOWN: begin
                if (!active) begin
                    phase_next      = PH_UP;
                    start_time_next = time_reg;
                end
            end
            PH_UP: begin
                phase_next = PH_COUNT;
                if (count_reg < COUNT_MAX) begin
                    count_next = count_reg + 2'd1;
                end
            end
            PH_COUNT: begin
                if (active) begin
                    phase_next      = PH_DOWN;
                    start_time_next = time_reg;
                end else if (elapsed >= TIME_W'(click_window_reg) ||
                             count_reg == max_clicks_reg) begin
                    if (count_reg == EV_SINGLE || count_reg == EV_DOUBLE) begin
                        kind_next   = count_reg;
                        button_next = 2'(slot_reg);
                    end
                    phase_next      = PH_IDLE;
                    start_time_next = '0;
                    count_next      = '0;
                end
            end
            default: ;
        endcase
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg   <= kind_next;
            button_reg <= button_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, button_reg, kind_reg};

`ifndef ASSERT_OFF
    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> count_reg == '0)
        else $error("count not clear while idle");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_COUNT |-> count_reg != '0)
        else $error("count phase with no click");

    a_event_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && kind_next != EV_NONE) |=> phase_reg == PH_IDLE)
        else $error("event reported without return to idle");

    a_event_from_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && kind_next != EV_NONE) |-> phase_reg == PH_COUNT)
        else $error("event reported outside count phase");
`endif

endmodule

/* tb/tb_ladder_button_click_detector.sv */
module tb_ladder_button_click_detector;
    import lbcd_pkg::*;

    // Predicts one result word per accepted sample and keeps the queue of words still owed.
    class click_scoreboard;
        typedef struct packed {
            logic [1:0] kind;
            logic [1:0] button;
        } click_event_t;

        logic [19:0]  windows [4];
        logic [15:0]  debounce_ms;
        logic [15:0]  click_window_ms;
        logic [1:0]   max_clicks;
        phase_t       phase;
        logic [31:0]  phase_start;
        logic [31:0]  last_change;
        logic [2:0]   last_raw;
        logic [2:0]   stable;
        logic [2:0]   latched;
        logic [1:0]   counts [4];
        click_event_t expected_events [$];
        int           errors;
        int           n_items;
        int           n_single;
        int           n_double;

        function new();
            foreach (windows[i]) windows[i] = '0;
            foreach (counts[i]) counts[i] = 2'd0;
            debounce_ms     = DEBOUNCE_RESET;
            click_window_ms = CLICK_RESET;
            max_clicks      = MAX_CLICKS_RESET;
            phase           = PH_IDLE;
            phase_start     = '0;
            last_change     = '0;
            last_raw        = 3'd0;
            stable          = 3'd0;
            latched         = 3'd0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_WINDOW_ONE:    windows[0] = data;
                REG_WINDOW_TWO:    windows[1] = data;
                REG_WINDOW_THREE:  windows[2] = data;
                REG_WINDOW_FOUR:   windows[3] = data;
                REG_DEBOUNCE_TIME: debounce_ms = data[15:0];
                REG_CLICK_WINDOW:  click_window_ms = data[15:0];
                REG_MAX_CLICKS:    max_clicks = data[1:0];
                default: ;
            endcase
        endfunction

        // first matching window wins, so scan from the last one down
        function logic [2:0] level_of(logic [9:0] sample);
            logic [2:0] lvl;
            lvl = 3'd0;
            for (int i = 3; i >= 0; i--) begin
                if (sample >= windows[i][9:0] && sample <= windows[i][19:10])
                    lvl = 3'(i + 1);
            end
            return lvl;
        endfunction

        function void note_sample(logic [9:0] sample, logic [31:0] now);
            logic [2:0]   raw;
            logic [31:0]  held;
            logic [31:0]  elapsed;
            logic [1:0]   slot;
            bit           active;
            click_event_t ev;
            raw  = level_of(sample);
            held = now - last_change;
            if (raw == last_raw) begin
                if (held >= {16'd0, debounce_ms})
                    stable = raw;
            end else begin
                last_change = now;
                last_raw    = raw;
            end
            active    = (stable != 3'd0);
            elapsed   = now - phase_start;
            slot      = latched[1:0] - 2'd1;
            ev.kind   = EV_NONE;
            ev.button = 2'd0;
            case (phase)
                PH_IDLE: begin
                    if (active) begin
                        phase       = PH_DOWN;
                        phase_start = now;
                        foreach (counts[i]) counts[i] = 2'd0;
                        latched     = stable;
                    end
                end
                PH_DOWN: begin
                    if (!active) begin
                        phase       = PH_UP;
                        phase_start = now;
                    end
                end
                PH_UP: begin
                    phase = PH_COUNT;
                    if (counts[slot] != COUNT_MAX)
                        counts[slot] = counts[slot] + 2'd1;
                end
                PH_COUNT: begin
                    if (active) begin
                        phase       = PH_DOWN;
                        phase_start = now;
                    end else if (elapsed >= {16'd0, click_window_ms}
                                 || counts[slot] == max_clicks) begin
                        // a saturated count of three ends the sequence silently
                        if (counts[slot] == EV_SINGLE || counts[slot] == EV_DOUBLE) begin
                            ev.kind   = counts[slot];
                            ev.button = slot;
                        end
                        phase       = PH_IDLE;
                        phase_start = '0;
                        foreach (counts[i]) counts[i] = 2'd0;
                    end
                end
            endcase
            expected_events.push_back(ev);
            n_items++;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [1:0] kind, logic [1:0] button);
            click_event_t want;
            if (expected_events.size() == 0) begin
                report($sformatf("result word kind %0d button %0d with nothing owed",
                                 kind, button));
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind)
                report($sformatf("event_kind %0d, predicted %0d", kind, want.kind));
            if (button !== want.button)
                report($sformatf("button_index %0d, predicted %0d", button, want.button));
            if (want.kind == EV_SINGLE)
                n_single++;
            else if (want.kind == EV_DOUBLE)
                n_double++;
        endtask
    endclass

    localparam int unsigned CYCLE_LIMIT = 600000;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [47:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    click_scoreboard sb = new();
    logic [31:0]     now_ms;
    bit              calm;
    int              rx_hold_len;
    int              n_phases;

    ladder_button_click_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still owed", cycle_count, sb.pending());
        $display("ladder_button_click_detector verification failed");
        $finish;
    end

    // result side: check each accepted word, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[1:0], m_tdata[3:2]);
        if (rx_hold_len > 0) begin
            rx_hold_len = rx_hold_len - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    task automatic send_item(logic [9:0] sample, logic [31:0] stamp);
        s_tdata  <= {6'd0, stamp, sample};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(sample, stamp);
        if (!calm && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [19:0] w [4], input logic [15:0] deb,
                                  input logic [15:0] cw, input logic [1:0] mx);
        cfg_write(REG_WINDOW_ONE, w[0]);
        cfg_write(REG_WINDOW_TWO, w[1]);
        cfg_write(REG_WINDOW_THREE, w[2]);
        cfg_write(REG_WINDOW_FOUR, w[3]);
        cfg_write(REG_DEBOUNCE_TIME, {4'd0, deb});
        cfg_write(REG_CLICK_WINDOW, {4'd0, cw});
        cfg_write(REG_MAX_CLICKS, {18'd0, mx});
        cfg_valid <= 1'b0;
        @(posedge aclk);
        n_phases++;
    endtask

    // drive one level for at least span ms; a few samples are random bounces
    task automatic hold_level(logic [2:0] level, int unsigned span);
        logic [31:0] t0;
        logic [31:0] stamp;
        logic [9:0]  s;
        int unsigned sent;
        int          tries;
        t0   = now_ms;
        sent = 0;
        do begin
            if ($urandom_range(0, 99) < 4) begin
                s = 10'($urandom);
            end else begin
                tries = 0;
                do begin
                    if (level != 3'd0 && tries < 20)
                        s = 10'($urandom_range(sb.windows[level-1][19:10],
                                               sb.windows[level-1][9:0]));
                    else
                        s = 10'($urandom);
                    tries++;
                end while (sb.level_of(s) != level && tries < 200);
            end
            stamp = now_ms;
            send_item(s, stamp);
            sent++;
            now_ms = now_ms + $urandom_range(0, span / 3 + 1);
        end while (sent < 2 || stamp - t0 < span);
    endtask

    task automatic click_burst();
        logic [2:0]  btn;
        int          clicks;
        int unsigned deb;
        int unsigned cw;
        deb    = sb.debounce_ms;
        cw     = sb.click_window_ms;
        btn    = 3'($urandom_range(1, 4));
        clicks = ($urandom_range(0, 9) < 5) ? 1 : $urandom_range(2, 4);
        repeat (clicks) begin
            // an occasional press shorter than the debounce time
            if ($urandom_range(0, 99) < 8)
                hold_level(btn, deb / 2);
            else
                hold_level(btn, deb + $urandom_range(0, deb / 2 + 3));
            hold_level(3'd0, deb + $urandom_range(0, cw / 2));
        end
        hold_level(3'd0, deb + cw + $urandom_range(1, 20));
    endtask

    task automatic noise_burst();
        int unsigned deb;
        deb = sb.debounce_ms;
        repeat ($urandom_range(3, 12)) begin
            send_item(10'($urandom), now_ms);
            if ($urandom_range(0, 99) < 10)
                now_ms = now_ms + $urandom;
            else
                now_ms = now_ms + $urandom_range(0, deb + 2);
        end
    endtask

    task automatic run_phase(logic [15:0] deb, logic [15:0] cw, logic [1:0] mx,
                             bit touch_ends, bit squeeze, int unsigned n);
        logic [19:0] w [4];
        logic [9:0]  lo;
        logic [9:0]  hi;
        int unsigned goal;
        wait_drain();
        for (int b = 0; b < 4; b++) begin
            lo   = 10'(b * 256 + $urandom_range(4, 60));
            hi   = 10'(b * 256 + $urandom_range(190, 250));
            w[b] = {hi, lo};
        end
        if (touch_ends) begin
            w[0][9:0]   = 10'd0;
            w[3][19:10] = 10'd1023;
        end
        apply_settings(w, deb, cw, mx);
        now_ms = $urandom;
        // receiver stalls long enough for both pipeline stages to fill
        if (squeeze)
            rx_hold_len = 300;
        goal = sb.n_items + n;
        while (sb.n_items < goal) begin
            if ($urandom_range(0, 99) < 85)
                click_burst();
            else
                noise_burst();
        end
    endtask

    initial begin : stimulus
        logic [19:0] w [4];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset windows are all [0,0]: sample 0 hits every window, the first one wins
        send_item(10'd0, 32'd0);
        send_item(10'd0, 32'd50);
        send_item(10'd1023, 32'd100);
        send_item(10'd1023, 32'd150);
        send_item(10'd1023, 32'd151);
        send_item(10'd1023, 32'd152);
        send_item(10'd512, 32'hFFFF_FFFF);
        wait_drain();

        // window three empty (min above max), window four only at full scale
        w[0] = {10'd99, 10'd0};
        w[1] = {10'd299, 10'd100};
        w[2] = {10'd300, 10'd400};
        w[3] = 20'hFFFFF;
        apply_settings(w, 16'd0, 16'd3, 2'd2);
        send_item(10'd1023, 32'd1000);
        send_item(10'd1023, 32'd1000);
        send_item(10'd500, 32'd1001);
        send_item(10'd500, 32'd1001);
        send_item(10'd250, 32'd1002);
        send_item(10'd250, 32'd1002);
        send_item(10'd500, 32'd1003);
        send_item(10'd500, 32'd1003);
        send_item(10'd350, 32'd1004);
        send_item(10'd0, 32'd1004);
        send_item(10'd0, 32'd1005);
        send_item(10'd1023, 32'd1005);
        send_item(10'd1023, 32'd1006);
        send_item(10'd700, 32'd1007);
        send_item(10'd700, 32'd1007);
        send_item(10'd700, 32'd1008);
        send_item(10'd700, 32'd1012);

        run_phase(16'd5, 16'd40, 2'd2, 1'b1, 1'b1, 320);
        calm = 1'b1;
        run_phase(16'd0, 16'd0, 2'd1, 1'b0, 1'b0, 300);
        calm = 1'b0;
        run_phase(16'hFFFF, 16'hFFFF, 2'd2, 1'b1, 1'b0, 150);
        run_phase(16'd3, 16'd30, 2'd3, 1'b0, 1'b0, 350);
        run_phase(16'd8, 16'd60, 2'd0, 1'b1, 1'b0, 300);
        run_phase(16'($urandom_range(0, 30)), 16'($urandom_range(10, 120)),
                  2'($urandom_range(1, 2)), 1'b0, 1'b0, 300);

        wait_drain();
        repeat (6) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.pending()));
        $display("covered %0d samples under %0d register settings", sb.n_items, n_phases);
        $display("saw %0d single and %0d double clicks, %0d mismatches",
                 sb.n_single, sb.n_double, sb.errors);
        if (sb.errors == 0) begin
            $display("ladder_button_click_detector verification clean");
        end else begin
            $display("ladder_button_click_detector verification failed");
        end
        $finish;
    end

endmodule
